### rtl/cbr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbr_pkg
// Shared types and constants for the CDMA correlator bit recovery block.
// ----------------------------------------------------------------------------
package cbr_pkg;

   localparam int CODE_W  = 16;
   localparam int SCORE_W = 29;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_DONE
   } state_type;

endpackage
// ----------------------------------------------------------------------------

### rtl/cdma_correlator_bit_recovery.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdma_correlator_bit_recovery
// Bank of N = CODE_LENGTH*OVERSAMPLE despreading correlators with bit recovery.
//
// Usage:
//   req_* carries one line sample per request (valid/stall). The block raises
//   req_stall while it works on a request, so a new request waits until the
//   last is through: N channel reads through a shared read-update-square-
//   accumulate pipeline over the channel state memory, pipeline drain, one
//   decision step (held while the output is stalled) and a return to idle.
//   rsp_* carries a result (valid/stall) only on a rising edge of the clock
//   vote, from the decision step for its request; otherwise a request
//   produces nothing. A held result sits in the output register; if a new
//   result is due while rsp_stall holds the old one, the block waits in its
//   decision step until the output frees up.
//   csr_* writes the spread code; csr_ready is always high. Write it only
//   while the block is idle.
//   Reset (synchronous, active high) starts a clearing pass over all N channels
//   that loads every channel's start phase; requests are stalled during it.
// ----------------------------------------------------------------------------
module cdma_correlator_bit_recovery #(
   parameter int CODE_LENGTH = 16,
   parameter int OVERSAMPLE  = 3
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_sample_bit,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_received_bit,
   output logic signed [cbr_pkg::SCORE_W-1:0]  rsp_data_score,
   output logic signed [cbr_pkg::SCORE_W-1:0]  rsp_clock_score,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic        [cbr_pkg::CODE_W-1:0]   csr_spread_code
);

   localparam int NCH   = CODE_LENGTH * OVERSAMPLE;
   localparam int HALF  = NCH / 2;
   localparam int AW    = $clog2(NCH);
   localparam int PW    = $clog2(NCH + 1);
   localparam int CW    = $clog2(CODE_LENGTH + 1);
   localparam int OPW   = $clog2(OVERSAMPLE + 1);
   localparam int WW    = 4 * PW;
   localparam int ACCW  = (5 * PW + 1 > cbr_pkg::SCORE_W) ? 5 * PW + 1 : cbr_pkg::SCORE_W;

   typedef struct packed {
      logic [PW-1:0]  pos;
      logic [PW-1:0]  hi;
      logic [PW-1:0]  lo;
      logic [PW-1:0]  distance;
      logic           bit_val;
      logic [CW-1:0]  chip;
      logic [OPW-1:0] phase;
   } chan_type;

   chan_type mem [NCH];

   cbr_pkg::state_type state_ff, state_in;

   logic [cbr_pkg::CODE_W-1:0] code_ff;
   logic [AW-1:0]              idx_ff, idx_in;
   logic [CW-1:0]              ichip_ff, ichip_in;
   logic [OPW-1:0]             iphase_ff, iphase_in;
   logic                       sample_ff, sample_in;
   logic                       seen_ff, seen_in;

   chan_type                   rdata_ff;
   logic [AW-1:0]              ridx_ff;
   logic                       v_rd_ff, v_rd_in;
   logic [2*PW-1:0]            sq_ff;
   logic                       dbit2_ff, cflag2_ff, v_sq_ff;
   logic [WW-1:0]              w_ff;
   logic                       dbit3_ff, cflag3_ff, v_w_ff;
   logic signed [ACCW-1:0]     acc_data_ff, acc_clk_ff;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_bit_ff;
   logic [cbr_pkg::SCORE_W-1:0] rsp_data_ff, rsp_clk_ff;

   logic     accept;
   logic     issue;
   logic     clr_we;
   logic     load_out;
   logic     emit;
   logic     clk_pos;
   logic     clk_neg;
   logic     out_free;
   chan_type upd;
   chan_type init_word;
   logic [CW+3:0] chip_x;
   logic     code_bit;
   logic     cflag;
   logic signed [ACCW-1:0] w_s;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != cbr_pkg::ST_IDLE);
   assign csr_ready = 1'b1;

   // Channel update for the word read last cycle
   always_comb begin
      upd = rdata_ff;
      if (upd.pos >= PW'(NCH)) begin
         upd.bit_val  = (rdata_ff.hi > rdata_ff.lo);
         upd.distance = (rdata_ff.hi > rdata_ff.lo) ? rdata_ff.hi - rdata_ff.lo
                                                    : rdata_ff.lo - rdata_ff.hi;
         upd.pos      = '0;
         upd.hi       = '0;
         upd.lo       = '0;
         upd.chip     = '0;
         upd.phase    = '0;
      end
      chip_x   = (CW + 4)'(upd.chip);
      code_bit = (chip_x < (CW + 4)'(16)) ? code_ff[chip_x[3:0]] : 1'b0;
      if (sample_ff == code_bit) begin
         upd.hi = upd.hi + PW'(1);
      end else begin
         upd.lo = upd.lo + PW'(1);
      end
      upd.pos = upd.pos + PW'(1);
      if (upd.phase == OPW'(OVERSAMPLE - 1)) begin
         upd.phase = '0;
         upd.chip  = upd.chip + CW'(1);
      end else begin
         upd.phase = upd.phase + OPW'(1);
      end
      cflag = (upd.pos > PW'(HALF));
   end

   always_comb begin
      init_word         = '0;
      init_word.pos     = PW'(idx_ff);
      init_word.chip    = ichip_ff;
      init_word.phase   = iphase_ff;
   end

   assign w_s      = $signed({{(ACCW - WW){1'b0}}, w_ff});
   assign clk_pos  = !acc_clk_ff[ACCW-1] && (acc_clk_ff != '0);
   assign clk_neg  = acc_clk_ff[ACCW-1];
   assign emit     = !seen_ff && clk_pos;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      ichip_in     = ichip_ff;
      iphase_in    = iphase_ff;
      sample_in    = sample_ff;
      seen_in      = seen_ff;
      issue        = 1'b0;
      clr_we       = 1'b0;
      load_out     = 1'b0;
      case (state_ff)
         cbr_pkg::ST_CLEAR: begin
            clr_we = 1'b1;
            if (iphase_ff == OPW'(OVERSAMPLE - 1)) begin
               iphase_in = '0;
               ichip_in  = ichip_ff + CW'(1);
            end else begin
               iphase_in = iphase_ff + OPW'(1);
            end
            if (idx_ff == AW'(NCH - 1)) begin
               idx_in   = '0;
               state_in = cbr_pkg::ST_IDLE;
            end else begin
               idx_in = idx_ff + AW'(1);
            end
         end
         cbr_pkg::ST_IDLE: begin
            if (accept) begin
               sample_in = req_sample_bit;
               idx_in    = '0;
               state_in  = cbr_pkg::ST_RUN;
            end
         end
         cbr_pkg::ST_RUN: begin
            issue = 1'b1;
            if (idx_ff == AW'(NCH - 1)) begin
               idx_in   = '0;
               state_in = cbr_pkg::ST_DRAIN;
            end else begin
               idx_in = idx_ff + AW'(1);
            end
         end
         cbr_pkg::ST_DRAIN: begin
            if (!v_rd_ff && !v_sq_ff && !v_w_ff) begin
               state_in = cbr_pkg::ST_DONE;
            end
         end
         cbr_pkg::ST_DONE: begin
            if (emit) begin
               if (out_free) begin
                  load_out = 1'b1;
                  seen_in  = 1'b1;
                  state_in = cbr_pkg::ST_IDLE;
               end
            end else begin
               if (seen_ff && clk_neg) begin
                  seen_in = 1'b0;
               end
               state_in = cbr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cbr_pkg::ST_IDLE;
         end
      endcase
   end

   assign v_rd_in = issue;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cbr_pkg::ST_CLEAR;
         idx_ff       <= '0;
         ichip_ff     <= '0;
         iphase_ff    <= '0;
         seen_ff      <= 1'b0;
         code_ff      <= '0;
         v_rd_ff      <= 1'b0;
         v_sq_ff      <= 1'b0;
         v_w_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         ichip_ff     <= ichip_in;
         iphase_ff    <= iphase_in;
         seen_ff      <= seen_in;
         v_rd_ff      <= v_rd_in;
         v_sq_ff      <= v_rd_ff;
         v_w_ff       <= v_sq_ff;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            code_ff <= csr_spread_code;
         end
      end
   end

   // Channel state memory
   always_ff @(posedge clock) begin
      if (clr_we) begin
         mem[idx_ff] <= init_word;
      end else if (v_rd_ff) begin
         mem[ridx_ff] <= upd;
      end
      if (issue) begin
         rdata_ff <= mem[idx_ff];
         ridx_ff  <= idx_ff;
      end
   end

   // Square, fourth power, accumulate
   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      sq_ff     <= (2 * PW)'(upd.distance) * (2 * PW)'(upd.distance);
      dbit2_ff  <= upd.bit_val;
      cflag2_ff <= cflag;
      w_ff      <= WW'(sq_ff) * WW'(sq_ff);
      dbit3_ff  <= dbit2_ff;
      cflag3_ff <= cflag2_ff;
      if (accept) begin
         acc_data_ff <= '0;
         acc_clk_ff  <= '0;
      end else if (v_w_ff) begin
         acc_data_ff <= dbit3_ff  ? acc_data_ff + w_s : acc_data_ff - w_s;
         acc_clk_ff  <= cflag3_ff ? acc_clk_ff + w_s  : acc_clk_ff - w_s;
      end
      if (load_out) begin
         rsp_bit_ff  <= !acc_data_ff[ACCW-1] && (acc_data_ff != '0);
         rsp_data_ff <= acc_data_ff[cbr_pkg::SCORE_W-1:0];
         rsp_clk_ff  <= acc_clk_ff[cbr_pkg::SCORE_W-1:0];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_received_bit = rsp_bit_ff;
   assign rsp_data_score   = $signed(rsp_data_ff);
   assign rsp_clock_score  = $signed(rsp_clk_ff);

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == cbr_pkg::ST_DONE))
      else $error("result raised outside decision step");

   a_rsp_sets_seen: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> seen_ff)
      else $error("result emitted without clock flag set");

   a_idle_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cbr_pkg::ST_IDLE) |-> !(v_rd_ff || v_sq_ff || v_w_ff))
      else $error("channel pipeline busy while idle");

   a_accept_runs: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == cbr_pkg::ST_RUN))
      else $error("accepted request did not start channel sweep");

endmodule
// ----------------------------------------------------------------------------

### tb/sv/cbr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbr_checker
// Watches the request, result and CSR channels of the correlator bank. It
// keeps its own copy of the channel state, predicts the recovered bit and
// both scores whenever an accepted request raises the clock vote, and compares
// each accepted result field by field with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module cbr_checker #(
   parameter int CODE_LENGTH = 16,
   parameter int OVERSAMPLE  = 3
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  logic                               req_sample_bit,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  logic                               rsp_received_bit,
   input  logic signed [cbr_pkg::SCORE_W-1:0] rsp_data_score,
   input  logic signed [cbr_pkg::SCORE_W-1:0] rsp_clock_score,
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  logic        [cbr_pkg::CODE_W-1:0]  csr_spread_code,
   output int                                 fail_count,
   output int                                 pending,
   output int                                 result_count
);

   localparam int CODE_W  = cbr_pkg::CODE_W;
   localparam int SCORE_W = cbr_pkg::SCORE_W;
   localparam int NCH = CODE_LENGTH * OVERSAMPLE;
   localparam int CW  = $clog2(NCH + 1);

   typedef struct packed {
      logic                      received_bit;
      logic signed [SCORE_W-1:0] data_score;
      logic signed [SCORE_W-1:0] clock_score;
   } recovered_bit_type;

   logic [CODE_W-1:0] code_q;
   logic [CW-1:0]     phase_q  [NCH];
   logic [CW-1:0]     hits_q   [NCH];
   logic [CW-1:0]     misses_q [NCH];
   logic [CW-1:0]     dist_q   [NCH];
   logic              bit_q    [NCH];
   logic              clock_high_q;

   recovered_bit_type expected_bits[$];
   int errors  = 0;
   int checked = 0;

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("cbr_checker: %0t %s: got %0d, expected %0d", $realtime, what, got, want);
      errors++;
   endtask

   // One line sample through every correlator; queues a bit on a rising clock vote.
   function automatic void correlate(input logic line_level);
      longint            data_sum;
      longint            clock_sum;
      longint            w;
      int                chip_idx;
      logic              chip;
      recovered_bit_type rb;
      data_sum  = 0;
      clock_sum = 0;
      for (int i = 0; i < NCH; i++) begin
         if (phase_q[i] >= NCH) begin
            bit_q[i]    = hits_q[i] > misses_q[i];
            dist_q[i]   = bit_q[i] ? hits_q[i] - misses_q[i] : misses_q[i] - hits_q[i];
            phase_q[i]  = '0;
            hits_q[i]   = '0;
            misses_q[i] = '0;
         end
         chip_idx = phase_q[i] / OVERSAMPLE;
         chip     = (chip_idx < CODE_W) ? code_q[chip_idx] : 1'b0;
         if (line_level == chip) hits_q[i]++;
         else misses_q[i]++;
         phase_q[i]++;
         w = longint'(dist_q[i]);
         w = w * w * w * w;
         data_sum  += bit_q[i] ? w : -w;
         clock_sum += (phase_q[i] > NCH / 2) ? w : -w;
      end
      if (!clock_high_q && clock_sum > 0) begin
         clock_high_q    = 1'b1;
         rb.received_bit = data_sum > 0;
         rb.data_score   = data_sum[SCORE_W-1:0];
         rb.clock_score  = clock_sum[SCORE_W-1:0];
         expected_bits.insert(expected_bits.size(), rb);
      end else if (clock_high_q && clock_sum < 0) begin
         clock_high_q = 1'b0;
      end
   endfunction

   always @(posedge clock) begin
      recovered_bit_type want;
      if (reset) begin
         code_q       = '0;
         clock_high_q = 1'b0;
         for (int i = 0; i < NCH; i++) begin
            phase_q[i]  = CW'(i);
            hits_q[i]   = '0;
            misses_q[i] = '0;
            dist_q[i]   = '0;
            bit_q[i]    = 1'b0;
         end
         expected_bits.delete();
      end else begin
         if (csr_valid && csr_ready) code_q = csr_spread_code;
         if (req_valid && !req_stall) correlate(req_sample_bit);
         if (rsp_valid && !rsp_stall) begin
            checked++;
            if (expected_bits.size() == 0) begin
               report_mismatch("result with none expected", rsp_data_score, 0);
            end else begin
               want = expected_bits.pop_front();
               if (rsp_received_bit !== want.received_bit)
                  report_mismatch("received_bit", rsp_received_bit, want.received_bit);
               if (rsp_data_score !== want.data_score)
                  report_mismatch("data_score", rsp_data_score, want.data_score);
               if (rsp_clock_score !== want.clock_score)
                  report_mismatch("clock_score", rsp_clock_score, want.clock_score);
            end
         end
      end
      pending      <= expected_bits.size();
      fail_count   <= errors;
      result_count <= checked;
   end

endmodule
// ----------------------------------------------------------------------------

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives spread line samples into the correlator bank: a short directed run
// over the sample and code extremes, then spread data bits with random code,
// phase, noise and slips under several idle and stall patterns. The checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int     CODE_W        = cbr_pkg::CODE_W;
   localparam int     SCORE_W       = cbr_pkg::SCORE_W;
   localparam int     CODE_LENGTH   = 16;
   localparam int     OVERSAMPLE    = 3;
   localparam int     NCH           = CODE_LENGTH * OVERSAMPLE;
   localparam int     DRAIN_CYCLES  = 100;
   localparam int     RANDOM_ITEMS  = 1200;
   localparam int     SEGMENT_ITEMS = 150;
   localparam longint CYCLE_LIMIT   = 1000000;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   logic              clock           = 1'b0;
   logic              reset           = 1'b1;
   logic              req_valid       = 1'b0;
   logic              req_sample_bit  = 1'b0;
   logic              rsp_stall       = 1'b0;
   logic              csr_valid       = 1'b0;
   logic [CODE_W-1:0] csr_spread_code = '0;

   logic                      req_stall;
   logic                      rsp_valid;
   logic                      rsp_received_bit;
   logic signed [SCORE_W-1:0] rsp_data_score;
   logic signed [SCORE_W-1:0] rsp_clock_score;
   logic                      csr_ready;

   int fail_count;
   int pending;
   int result_count;

   int                sender_idle_pct = 0;
   int                stall_pct       = 0;
   int                items_sent      = 0;
   longint            cycle_count     = 0;
   logic [CODE_W-1:0] code_now        = '0;
   int                tx_phase        = 0;
   logic              tx_bit          = 1'b0;
   int                burst_left      = 0;

   always #4 clock = ~clock;

   cdma_correlator_bit_recovery #(
      .CODE_LENGTH (CODE_LENGTH),
      .OVERSAMPLE  (OVERSAMPLE)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample_bit   (req_sample_bit),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_received_bit (rsp_received_bit),
      .rsp_data_score   (rsp_data_score),
      .rsp_clock_score  (rsp_clock_score),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_spread_code  (csr_spread_code)
   );

   cbr_checker #(
      .CODE_LENGTH (CODE_LENGTH),
      .OVERSAMPLE  (OVERSAMPLE)
   ) bit_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample_bit   (req_sample_bit),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_received_bit (rsp_received_bit),
      .rsp_data_score   (rsp_data_score),
      .rsp_clock_score  (rsp_clock_score),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_spread_code  (csr_spread_code),
      .fail_count       (fail_count),
      .pending          (pending),
      .result_count     (result_count)
   );

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   task automatic send_sample(input logic level);
      while ($urandom_range(99) < sender_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid      <= 1'b1;
      req_sample_bit <= level;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   task automatic write_code(input logic [CODE_W-1:0] value);
      @(negedge clock);
      csr_valid       <= 1'b1;
      csr_spread_code <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      code_now = value;
   endtask

   // drop valid, wait out every expected bit, then the block's own latency
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // spread transmitter: code chips for a 1, inverted for a 0; noise bursts and slips
   function automatic logic next_line_level();
      logic level;
      if (burst_left > 0) begin
         burst_left--;
         return logic'($urandom_range(1));
      end
      level = code_now[tx_phase / OVERSAMPLE] ~^ tx_bit;
      if ($urandom_range(19) == 0) level = ~level;
      tx_phase++;
      if (tx_phase == NCH) begin
         tx_phase = 0;
         tx_bit   = logic'($urandom_range(1));
         if ($urandom_range(9) == 0) burst_left = $urandom_range(20, 1);
         else if ($urandom_range(9) == 0) tx_phase = $urandom_range(NCH - 1);
      end
      return level;
   endfunction

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_top: done, errors");
      $finish;
   end

   initial begin
      int segment;
      segment = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      settle();

      // directed: zero code with alternating samples (ties, zero scores), then all-ones code
      write_code(16'h0000);
      for (int k = 0; k < 12; k++) send_sample(logic'(k % 2));
      settle();
      write_code(16'hFFFF);
      for (int k = 0; k < 13; k++) send_sample(k < 8);
      settle();

      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         case (idle_mode_type'(segment % 4))
            IDLE_NONE: begin
               sender_idle_pct = 0;
               stall_pct       = 0;
            end
            IDLE_SENDER: begin
               sender_idle_pct = 79;
               stall_pct       = 0;
            end
            IDLE_RECEIVER: begin
               sender_idle_pct = 0;
               stall_pct       = 79;
            end
            default: begin
               sender_idle_pct = 29;
               stall_pct       = 29;
            end
         endcase
         if (segment % 5 == 4) write_code($urandom_range(1) ? 16'hFFFF : 16'h0000);
         else write_code(CODE_W'($urandom));
         tx_phase   = $urandom_range(NCH - 1);
         tx_bit     = logic'($urandom_range(1));
         burst_left = 0;
         repeat (SEGMENT_ITEMS) send_sample(next_line_level());
         settle();
         segment++;
      end

      if (fail_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule
// ----------------------------------------------------------------------------
